// ===== rtl/midi_message_queue_note_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// midi message queue assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef MIDI_MESSAGE_QUEUE_NOTE_TRACKER_ASSERT_SVH
`define MIDI_MESSAGE_QUEUE_NOTE_TRACKER_ASSERT_SVH

// checked outside reset
`define MMQNT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define MMQNT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mmqnt_pkg.sv =====
// ----------------------------------------------------------------------------
// mmqnt_pkg
// shared constants, types and helpers of the midi message queue
// ----------------------------------------------------------------------------
package mmqnt_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int NOTE_SLOTS  = 2048;
    localparam int NOTE_AW     = $clog2(NOTE_SLOTS);
    localparam int NOTE_BITS   = 7;

    localparam int OP_W         = 3;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 32;
    localparam int OUT_FIELDS_W = 27;

    localparam logic [OP_W-1:0] OP_ENQ_BYTE = 3'd0;
    localparam logic [OP_W-1:0] OP_ENQ_MSG  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEQ_MSG  = 3'd2;
    localparam logic [OP_W-1:0] OP_FLUSH    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

    localparam logic [7:0] SYSEX_START    = 8'hF0;
    localparam logic [7:0] SYSEX_END      = 8'hF7;
    localparam logic [7:0] FLUSH_VELOCITY = 8'd64;

    localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
    localparam logic [3:0] ST_NOTE_ON   = 4'h9;
    localparam logic [3:0] ST_POLY_AT   = 4'hA;
    localparam logic [3:0] ST_CTRL      = 4'hB;
    localparam logic [3:0] ST_PROGRAM   = 4'hC;
    localparam logic [3:0] ST_CHAN_AT   = 4'hD;
    localparam logic [3:0] ST_PITCHBEND = 4'hE;

    typedef enum logic [1:0] {
        BS_FIRST,
        BS_SECOND,
        BS_THIRD
    } t_byte_sel;

    typedef struct packed {
        logic      start;
        logic      eb;
        logic      push;
        logic      push_flush;
        t_byte_sel push_sel;
        logic      pop;
        logic      cap_status;
        logic      cap_d1;
        logic      cap_d2;
        logic      set_warn;
        logic      q_clear;
        logic      cnt_inc;
        logic      note_sel_cnt;
        logic      note_clr;
        logic      note_upd;
        logic      load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            em_ok;
        logic            em_room;
        logic            em_three;
        logic            empty;
        logic            dq_skip;
        logic            dq_ok;
        logic            taken_three;
        logic            note_active;
        logic            fl_room;
        logic            cnt_last;
        logic            out_busy;
    } t_dp_status;

    // bytes in a channel message with this status, 0 if not a channel message
    function automatic logic [1:0] msg_size(input logic [7:0] status);
        logic [1:0] size;
        case (status[7:4]) inside
            ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CTRL, ST_PITCHBEND: size = 2'd3;
            ST_PROGRAM, ST_CHAN_AT:                                      size = 2'd2;
            default:                                                     size = 2'd0;
        endcase
        return size;
    endfunction

endpackage

// ===== rtl/mmqnt_dp.sv =====
// ----------------------------------------------------------------------------
// mmqnt_dp
// queue memory, pointers, note count memory, result and output registers
// ----------------------------------------------------------------------------
module mmqnt_dp import mmqnt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic [OP_W-1:0]        i_in_op,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0] o_out_data
);

    logic [OP_W-1:0]        r_op;
    logic [7:0]             r_b0;
    logic [7:0]             r_b1;
    logic [7:0]             r_b2;
    logic [1:0]             r_len;

    logic [PTR_W-1:0]       r_rp;
    logic [FILL_W-1:0]      r_fill;
    logic                   r_sysex;
    logic [NOTE_AW-1:0]     r_cnt;

    logic [1:0]             r_taken;
    logic [7:0]             r_status;
    logic [7:0]             r_d1;
    logic [7:0]             r_d2;
    logic                   r_warn;

    logic [7:0]             r_queue_mem [QUEUE_DEPTH];
    logic [7:0]             r_rd;
    logic [7:0]             r_note_mem [NOTE_SLOTS];
    logic [7:0]             r_note_rd;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [FILL_W:0]        wsum;
    logic [FILL_W:0]        wsum_adj;
    logic [PTR_W-1:0]       wp;
    logic [FILL_W-1:0]      room;
    logic                   full;
    logic                   eb_ok;
    logic                   q_we;
    logic [7:0]             q_wdata;
    logic [7:0]             push_data;
    logic [1:0]             em_need;
    logic [1:0]             front_need;
    logic [NOTE_AW-1:0]     note_idx;
    logic [NOTE_AW-1:0]     note_addr;
    logic                   note_we;
    logic [7:0]             note_wdata;
    logic [7:0]             note_inc;

    assign full       = r_fill == FILL_W'(QUEUE_DEPTH);
    assign room       = FILL_W'(QUEUE_DEPTH) - r_fill;
    assign wsum       = (FILL_W+1)'(r_rp) + (FILL_W+1)'(r_fill);
    assign wsum_adj   = (wsum >= (FILL_W+1)'(QUEUE_DEPTH)) ?
                        wsum - (FILL_W+1)'(QUEUE_DEPTH) : wsum;
    assign wp         = wsum_adj[PTR_W-1:0];
    assign eb_ok      = !r_sysex && (r_b0 != SYSEX_START) && !full;
    assign em_need    = msg_size(r_b0);
    assign front_need = msg_size(r_rd);

    always_comb begin
        case (i_cmd.push_sel)
            BS_FIRST:  push_data = i_cmd.push_flush ?
                                   {ST_NOTE_OFF, r_cnt[NOTE_AW-1:NOTE_BITS]} : r_b0;
            BS_SECOND: push_data = i_cmd.push_flush ?
                                   {1'b0, r_cnt[NOTE_BITS-1:0]} : r_b1;
            BS_THIRD:  push_data = i_cmd.push_flush ? FLUSH_VELOCITY : r_b2;
            default:   push_data = 8'd0;
        endcase
    end

    assign q_we    = i_cmd.push || (i_cmd.eb && eb_ok);
    assign q_wdata = i_cmd.eb ? r_b0 : push_data;

    assign note_idx   = {r_status[3:0], r_d1[NOTE_BITS-1:0]};
    assign note_addr  = i_cmd.note_sel_cnt ? r_cnt : note_idx;
    assign note_inc   = (r_note_rd == 8'hFF) ? r_note_rd : r_note_rd + 8'd1;
    assign note_we    = i_cmd.note_clr ||
                        (i_cmd.note_upd &&
                         (r_status[7:4] == ST_NOTE_OFF || r_status[7:4] == ST_NOTE_ON));
    assign note_wdata = (i_cmd.note_upd && r_status[7:4] == ST_NOTE_ON) ? note_inc : 8'd0;

    // memories
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_queue_mem[wp] <= q_wdata;
        end
        r_rd <= r_queue_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (note_we) begin
            r_note_mem[note_addr] <= note_wdata;
        end
        r_note_rd <= r_note_mem[note_addr];
    end

    // queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp    <= '0;
            r_fill  <= '0;
            r_sysex <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.q_clear) begin
                r_rp    <= '0;
                r_fill  <= '0;
                r_sysex <= 1'b0;
            end else begin
                if (q_we) begin
                    r_fill <= r_fill + FILL_W'(1);
                end else if (i_cmd.pop) begin
                    r_fill <= r_fill - FILL_W'(1);
                    r_rp   <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
                end
                if (i_cmd.eb && !eb_ok) begin
                    if (r_b0 == SYSEX_START) begin
                        r_sysex <= 1'b1;
                    end else if (r_b0 == SYSEX_END) begin
                        r_sysex <= 1'b0;
                    end
                end
            end
            if (i_cmd.start) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + NOTE_AW'(1);
            end
        end
    end

    // request and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op     <= i_in_op;
            r_b0     <= i_in_data[7:0];
            r_b1     <= i_in_data[15:8];
            r_b2     <= i_in_data[23:16];
            r_len    <= i_in_data[25:24];
            r_taken  <= 2'd0;
            r_status <= 8'd0;
            r_d1     <= 8'd0;
            r_d2     <= 8'd0;
            r_warn   <= 1'b0;
        end else begin
            if (i_cmd.cap_status) begin
                r_status <= r_rd;
                r_taken  <= front_need;
            end
            if (i_cmd.cap_d1) begin
                r_d1 <= r_rd;
            end
            if (i_cmd.cap_d2) begin
                r_d2 <= r_rd;
            end
            if (i_cmd.set_warn || (i_cmd.eb && full)) begin
                r_warn <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {(OUT_TDATA_W - OUT_FIELDS_W)'(0),
                           r_warn, r_d2, r_d1, r_status, r_taken};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        o_status.op          = r_op;
        o_status.full        = full;
        o_status.em_ok       = (em_need != 2'd0) && (em_need == r_len);
        o_status.em_room     = FILL_W'(em_need) <= room;
        o_status.em_three    = em_need == 2'd3;
        o_status.empty       = r_fill == '0;
        o_status.dq_skip     = front_need == 2'd0;
        o_status.dq_ok       = (r_len >= front_need) && (r_fill >= FILL_W'(front_need));
        o_status.taken_three = r_taken == 2'd3;
        o_status.note_active = r_note_rd != 8'd0;
        o_status.fl_room     = room >= FILL_W'(3);
        o_status.cnt_last    = r_cnt == NOTE_AW'(NOTE_SLOTS - 1);
        o_status.out_busy    = r_out_valid && !i_out_ready;
    end

endmodule

// ===== rtl/mmqnt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmqnt_ctrl
// sequencer for the five queue operations and the note count sweeps
// ----------------------------------------------------------------------------
module mmqnt_ctrl import mmqnt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_EM_WR,
        S_DQ_WAIT,
        S_DQ_CHK,
        S_DQ_W1,
        S_DQ_C1,
        S_DQ_W2,
        S_DQ_C2,
        S_NT_WAIT,
        S_NT_UPD,
        S_FL_RD,
        S_FL_CHK,
        S_FL_WR,
        S_CLR,
        S_DONE
    } t_state;

    t_state    r_state;
    t_state    n_state;
    t_byte_sel r_k;
    t_byte_sel n_k;
    logic      k_next;

    assign o_in_ready = r_state == S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_k     <= BS_FIRST;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_k      = r_k;
        k_next   = 1'b0;
        o_cmd.push_sel = r_k;
        unique case (r_state)
            S_INIT: begin
                o_cmd.note_sel_cnt = 1'b1;
                o_cmd.note_clr     = 1'b1;
                o_cmd.cnt_inc      = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_k = BS_FIRST;
                unique case (i_status.op)
                    OP_ENQ_BYTE: begin
                        o_cmd.eb = 1'b1;
                        n_state  = S_DONE;
                    end
                    OP_ENQ_MSG: begin
                        if (i_status.em_ok && i_status.em_room) begin
                            n_state = S_EM_WR;
                        end else begin
                            o_cmd.set_warn = i_status.em_ok;
                            n_state        = S_DONE;
                        end
                    end
                    OP_DEQ_MSG: n_state = S_DQ_CHK;
                    OP_FLUSH:   n_state = S_FL_RD;
                    OP_CLEAR:   n_state = S_CLR;
                    default:    n_state = S_DONE;
                endcase
            end
            S_EM_WR: begin
                o_cmd.push = 1'b1;
                k_next     = 1'b1;
                if (r_k == BS_THIRD || (r_k == BS_SECOND && !i_status.em_three)) begin
                    n_state = S_DONE;
                end
            end
            S_DQ_WAIT: begin
                n_state = S_DQ_CHK;
            end
            S_DQ_CHK: begin
                if (i_status.empty) begin
                    n_state = S_DONE;
                end else if (i_status.dq_skip) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_DQ_WAIT;
                end else if (i_status.dq_ok) begin
                    o_cmd.cap_status = 1'b1;
                    o_cmd.pop        = 1'b1;
                    n_state          = S_DQ_W1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DQ_W1: begin
                n_state = S_DQ_C1;
            end
            S_DQ_C1: begin
                o_cmd.cap_d1 = 1'b1;
                o_cmd.pop    = 1'b1;
                n_state      = i_status.taken_three ? S_DQ_W2 : S_NT_WAIT;
            end
            S_DQ_W2: begin
                n_state = S_DQ_C2;
            end
            S_DQ_C2: begin
                o_cmd.cap_d2 = 1'b1;
                o_cmd.pop    = 1'b1;
                n_state      = S_NT_WAIT;
            end
            S_NT_WAIT: begin
                n_state = S_NT_UPD;
            end
            S_NT_UPD: begin
                o_cmd.note_upd = 1'b1;
                n_state        = S_DONE;
            end
            S_FL_RD: begin
                o_cmd.note_sel_cnt = 1'b1;
                n_state            = S_FL_CHK;
            end
            S_FL_CHK: begin
                o_cmd.note_sel_cnt = 1'b1;
                n_k                = BS_FIRST;
                if (i_status.note_active && !i_status.full) begin
                    o_cmd.note_clr = 1'b1;
                end
                if (i_status.note_active && !i_status.full && i_status.fl_room) begin
                    n_state = S_FL_WR;
                end else begin
                    o_cmd.set_warn = i_status.note_active && !i_status.full;
                    o_cmd.cnt_inc  = 1'b1;
                    n_state        = i_status.cnt_last ? S_DONE : S_FL_RD;
                end
            end
            S_FL_WR: begin
                o_cmd.note_sel_cnt = 1'b1;
                o_cmd.push         = 1'b1;
                o_cmd.push_flush   = 1'b1;
                k_next             = 1'b1;
                if (r_k == BS_THIRD) begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = i_status.cnt_last ? S_DONE : S_FL_RD;
                end
            end
            S_CLR: begin
                o_cmd.q_clear      = 1'b1;
                o_cmd.note_sel_cnt = 1'b1;
                o_cmd.note_clr     = 1'b1;
                o_cmd.cnt_inc      = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (k_next) begin
            n_k = t_byte_sel'(2'(r_k + 2'd1));
        end
    end

endmodule

// ===== rtl/midi_message_queue_note_tracker.sv =====
// ----------------------------------------------------------------------------
// midi_message_queue_note_tracker
// byte queue for midi channel messages with active note tracking
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser op, tdata message bytes
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata dequeued message, warning
//
//  an enqueue message request may be refused; dequeue first discards leading
//  bytes that start no channel message, then takes the message.
//  flush walks all 2048 note count slots and queues a note-off per active note
//  that fits. clear sweeps the note count memory; after reset the same
//  clearing pass runs with s_axis_tready low.
//  a result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module midi_message_queue_note_tracker import mmqnt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // first_byte, second_byte, third_byte, length
    input  logic [OP_W-1:0]        s_axis_tuser,   // op
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // taken_count, out_status, out_data1,
                                                   // out_data2, full_warning
);

    t_dp_cmd    cmd;
    t_dp_status status;

    mmqnt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mmqnt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_in_op     (s_axis_tuser),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== rtl/mmqnt_checker.sv =====
// ----------------------------------------------------------------------------
// mmqnt_checker
// port level checks of the midi message queue, bound to the top level
// ----------------------------------------------------------------------------
`include "midi_message_queue_note_tracker_assert.svh"

module mmqnt_checker import mmqnt_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [OP_W-1:0]        s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [OP_W+IN_TDATA_W-1:0] in_req;

    assign in_req = {s_axis_tuser, s_axis_tdata};

    // stalled request holds
    `MMQNT_ASSERT(a_in_hold, i_clk, i_rst_n, s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(in_req), "stalled request changed")

    // stalled result holds
    `MMQNT_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // a dequeued message is never a single byte
    `MMQNT_ASSERT(a_no_single, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd1, "one byte message returned")

    // no message taken means no message bytes
    `MMQNT_ASSERT(a_empty_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[1:0] == 2'd0 |-> m_axis_tdata[25:2] == 24'd0, "message bytes without a message")

    // reset starts the clearing pass with both sides quiet
    `MMQNT_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !s_axis_tready && !m_axis_tvalid, "handshake active after reset")

endmodule

bind midi_message_queue_note_tracker mmqnt_checker u_checker (.*);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the midi message queue with note tracking: a
// scoreboard keeps its own copy of the queue, the sysex flag and the note
// counts, predicts one response per accepted request and compares every
// response field by field; both stream sides idle at random
// ----------------------------------------------------------------------------
module tb;
    import mmqnt_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO    = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI    = 3'd7;
    localparam logic [3:0]      ST_SYSTEM      = 4'hF;
    localparam int              WATCHDOG_LIMIT = 60000;
    localparam int              TAIL_CYCLES    = 100;

    typedef struct packed {
        logic [1:0] taken;
        logic [7:0] status;
        logic [7:0] data1;
        logic [7:0] data2;
        logic       warn;
    } midi_response_t;

    class midi_queue_scoreboard;
        logic [7:0]     queue_bytes [QUEUE_DEPTH];
        int unsigned    head;
        int unsigned    level;
        bit             sysex_open;
        logic [7:0]     active_notes [NOTE_SLOTS];
        midi_response_t expected_responses [$];
        int unsigned    errors;

        function new();
            clear_state();
            errors = 0;
        endfunction

        function void clear_state();
            head       = 0;
            level      = 0;
            sysex_open = 1'b0;
            foreach (active_notes[i]) active_notes[i] = '0;
        endfunction

        function int unsigned message_bytes(input logic [7:0] status);
            case (status[7:4])
                ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CTRL, ST_PITCHBEND: return 3;
                ST_PROGRAM, ST_CHAN_AT: return 2;
                default: return 0;
            endcase
        endfunction

        function void push_byte(input logic [7:0] value);
            queue_bytes[(head + level) % QUEUE_DEPTH] = value;
            level++;
        endfunction

        function logic [7:0] pop_byte();
            logic [7:0] value;
            value = queue_bytes[head];
            head  = (head + 1) % QUEUE_DEPTH;
            level--;
            return value;
        endfunction

        // 1 when a well-formed message does not fit
        function bit put_message(input logic [7:0] m0, m1, m2, input int unsigned n);
            int unsigned need;
            need = message_bytes(m0);
            if (need == 0 || need != n) return 1'b0;
            if (n > QUEUE_DEPTH - level) return 1'b1;
            push_byte(m0);
            push_byte(m1);
            if (n == 3) push_byte(m2);
            return 1'b0;
        endfunction

        function void note_request(input logic [OP_W-1:0] op, input logic [7:0] b0, b1, b2,
                                   input logic [1:0] len);
            midi_response_t rsp;
            int unsigned    need;
            logic [10:0]    slot;
            rsp = '0;
            case (op)
                OP_ENQ_BYTE: begin
                    if (!sysex_open && b0 != SYSEX_START && level < QUEUE_DEPTH) begin
                        push_byte(b0);
                    end else begin
                        if (b0 == SYSEX_START) sysex_open = 1'b1;
                        else if (b0 == SYSEX_END) sysex_open = 1'b0;
                        rsp.warn = (level >= QUEUE_DEPTH);
                    end
                end
                OP_ENQ_MSG: begin
                    rsp.warn = put_message(b0, b1, b2, len);
                end
                OP_DEQ_MSG: begin
                    // leading bytes that start no channel message are dropped
                    while (level > 0 && message_bytes(queue_bytes[head]) == 0) void'(pop_byte());
                    need = (level > 0) ? message_bytes(queue_bytes[head]) : 0;
                    if (need != 0 && len >= need && level >= need) begin
                        rsp.taken  = 2'(need);
                        rsp.status = pop_byte();
                        rsp.data1  = pop_byte();
                        if (need == 3) rsp.data2 = pop_byte();
                        slot = {rsp.status[3:0], rsp.data1[6:0]};
                        if (rsp.status[7:4] == ST_NOTE_OFF) begin
                            active_notes[slot] = '0;
                        end else if (rsp.status[7:4] == ST_NOTE_ON && active_notes[slot] != 8'hFF) begin
                            active_notes[slot]++;
                        end
                    end
                end
                OP_FLUSH: begin
                    for (int i = 0; i < NOTE_SLOTS; i++) begin
                        slot = 11'(i);
                        if (active_notes[i] != 0 && level < QUEUE_DEPTH) begin
                            if (put_message({ST_NOTE_OFF, slot[10:7]}, {1'b0, slot[6:0]},
                                            FLUSH_VELOCITY, 3)) rsp.warn = 1'b1;
                            active_notes[i] = '0;
                        end
                    end
                end
                OP_CLEAR: begin
                    clear_state();
                end
                default: ;
            endcase
            expected_responses.insert(expected_responses.size(), rsp);
        endfunction

        function void compare_field(input string name, input logic [7:0] want, got);
            if (want !== got) begin
                errors++;
                $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(input logic [OUT_TDATA_W-1:0] word);
            midi_response_t want;
            if (expected_responses.size() == 0) begin
                errors++;
                $display("%0t unexpected response: expected none actual %h", $time, word);
                return;
            end
            want = expected_responses[0];
            expected_responses.delete(0);
            compare_field("taken_count",  8'(want.taken), 8'(word[1:0]));
            compare_field("out_status",   want.status,    word[9:2]);
            compare_field("out_data1",    want.data1,     word[17:10]);
            compare_field("out_data2",    want.data2,     word[25:18]);
            compare_field("full_warning", 8'(want.warn),  8'(word[26]));
        endfunction

        function int unsigned outstanding();
            return expected_responses.size();
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // first_byte, second_byte, third_byte, length
    logic [OP_W-1:0]        s_axis_tuser  = '0;   // op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // taken_count, out_status, out_data1,
                                                  // out_data2, full_warning

    midi_queue_scoreboard sb = new();
    bit                   tx_steady    = 1'b0;
    bit                   rx_steady    = 1'b0;
    int unsigned          quiet_cycles = 0;

    always #1 i_clk = ~i_clk;

    midi_message_queue_note_tracker u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    task automatic send_request(input logic [OP_W-1:0] op, input logic [7:0] b0, b1, b2,
                                input logic [1:0] len);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, len, b2, b1, b0};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(op, b0, b1, b2, len);
    endtask

    // hold off new requests until every response is back
    task automatic drain_responses();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    task automatic random_request(input int unsigned enq_share);
        int unsigned     r;
        int unsigned     kind;
        logic [OP_W-1:0] op;
        logic [7:0]      b0;
        logic [7:0]      b1;
        logic [7:0]      b2;
        logic [1:0]      len;
        r   = $urandom_range(0, 99);
        b0  = 8'($urandom);
        b1  = 8'($urandom);
        b2  = 8'($urandom);
        len = 2'($urandom);
        if (r < 2) begin
            op = OP_FLUSH;
        end else if (r < 3) begin
            op = OP_CLEAR;
        end else if (r < 4) begin
            op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end else if (r < 4 + enq_share) begin
            if ($urandom_range(0, 3) == 0) begin
                op   = OP_ENQ_BYTE;
                kind = $urandom_range(0, 9);
                if (kind == 0) b0 = SYSEX_START;
                else if (kind == 1) b0 = SYSEX_END;
                else if (kind < 5) b0[7] = 1'b0;
                else if (kind < 8) b0[7:4] = 4'($urandom_range(ST_NOTE_OFF, ST_PITCHBEND));
            end else begin
                op   = OP_ENQ_MSG;
                kind = $urandom_range(0, 19);
                if (kind < 7) b0[7:4] = ST_NOTE_ON;
                else if (kind < 11) b0[7:4] = ST_NOTE_OFF;
                else if (kind < 18) b0[7:4] = 4'($urandom_range(ST_POLY_AT, ST_PITCHBEND));
                // few channels and notes so that note counts collide
                if ($urandom_range(0, 3) != 0) b0[3:0] = 4'($urandom_range(0, 3));
                if ($urandom_range(0, 3) != 0) b1 = {b1[7], 5'b01111, b1[1:0]};
                if ($urandom_range(0, 9) != 0)
                    len = (b0[7:4] == ST_PROGRAM || b0[7:4] == ST_CHAN_AT) ? 2'd2 : 2'd3;
            end
        end else begin
            op = OP_DEQ_MSG;
            if ($urandom_range(0, 4) != 0) len = 2'd3;
        end
        send_request(op, b0, b1, b2, len);
    endtask

    // fills the queue to the brim three times over with note-ons for one note,
    // so the count of that note runs into saturation
    task automatic saturate_note();
        send_request(OP_CLEAR, 8'h00, 8'h00, 8'h00, 2'd0);
        for (int round = 0; round < 3; round++) begin
            for (int i = 0; i < 85; i++)
                send_request(OP_ENQ_MSG, {ST_NOTE_ON, 4'h9}, 8'h55, 8'h40, 2'd3);
            send_request(OP_ENQ_MSG, {ST_NOTE_ON, 4'h9}, 8'h55, 8'h40, 2'd3);
            send_request(OP_ENQ_BYTE, 8'h11, 8'h00, 8'h00, 2'd0);
            send_request(OP_ENQ_BYTE, 8'h22, 8'h00, 8'h00, 2'd0);
            for (int i = 0; i < 86; i++)
                send_request(OP_DEQ_MSG, 8'h00, 8'h00, 8'h00, 2'd3);
        end
        send_request(OP_ENQ_MSG, {ST_NOTE_ON, 4'h9}, 8'h55, 8'h40, 2'd3);
        send_request(OP_DEQ_MSG, 8'h00, 8'h00, 8'h00, 2'd3);
        send_request(OP_FLUSH, 8'h00, 8'h00, 8'h00, 2'd0);
        send_request(OP_DEQ_MSG, 8'h00, 8'h00, 8'h00, 2'd3);
        send_request(OP_DEQ_MSG, 8'h00, 8'h00, 8'h00, 2'd3);
    endtask

    initial begin
        int unsigned sent;
        int unsigned burst_len;
        int unsigned share;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(OP_DEQ_MSG,  8'h00, 8'h00, 8'h00, 2'd3);
        send_request(OP_ENQ_BYTE, 8'h00, 8'h00, 8'h00, 2'd0);
        send_request(OP_ENQ_BYTE, 8'hFF, 8'hFF, 8'hFF, 2'd3);
        send_request(OP_ENQ_BYTE, SYSEX_START, 8'h00, 8'h00, 2'd0);
        send_request(OP_ENQ_BYTE, {ST_NOTE_ON, 4'h0}, 8'h00, 8'h00, 2'd0);
        send_request(OP_ENQ_BYTE, SYSEX_END, 8'h00, 8'h00, 2'd0);
        send_request(OP_ENQ_BYTE, {ST_NOTE_ON, 4'h0}, 8'h00, 8'h00, 2'd0);
        send_request(OP_ENQ_BYTE, 8'h3C, 8'h00, 8'h00, 2'd0);
        send_request(OP_ENQ_BYTE, 8'h7F, 8'h00, 8'h00, 2'd0);
        send_request(OP_DEQ_MSG,  8'h00, 8'h00, 8'h00, 2'd3);
        send_request(OP_ENQ_MSG,  {ST_PROGRAM, 4'h5}, 8'h12, 8'hAA, 2'd2);
        send_request(OP_DEQ_MSG,  8'h00, 8'h00, 8'h00, 2'd1);
        send_request(OP_DEQ_MSG,  8'h00, 8'h00, 8'h00, 2'd2);
        send_request(OP_ENQ_MSG,  {ST_NOTE_ON, 4'hF}, 8'hFF, 8'hFF, 2'd3);
        send_request(OP_DEQ_MSG,  8'h00, 8'h00, 8'h00, 2'd3);
        send_request(OP_ENQ_MSG,  {ST_NOTE_OFF, 4'h0}, 8'h3C, 8'h00, 2'd2);
        send_request(OP_ENQ_MSG,  {ST_SYSTEM, 4'h3}, 8'h01, 8'h02, 2'd3);
        send_request(OP_ENQ_BYTE, {ST_NOTE_OFF, 4'h0}, 8'h00, 8'h00, 2'd0);
        send_request(OP_DEQ_MSG,  8'h00, 8'h00, 8'h00, 2'd3);
        send_request(OP_ENQ_BYTE, 8'h40, 8'h00, 8'h00, 2'd0);
        send_request(OP_ENQ_BYTE, 8'h00, 8'h00, 8'h00, 2'd0);
        send_request(OP_DEQ_MSG,  8'h00, 8'h00, 8'h00, 2'd0);
        send_request(OP_DEQ_MSG,  8'h00, 8'h00, 8'h00, 2'd3);
        send_request(OP_FLUSH,    8'h00, 8'h00, 8'h00, 2'd0);
        send_request(OP_DEQ_MSG,  8'h00, 8'h00, 8'h00, 2'd3);
        send_request(OP_DEQ_MSG,  8'h00, 8'h00, 8'h00, 2'd3);
        send_request(OP_SPARE_LO, 8'hFF, 8'hFF, 8'hFF, 2'd3);
        send_request(OP_SPARE_HI, 8'h00, 8'h00, 8'h00, 2'd0);
        send_request(OP_CLEAR,    8'h00, 8'h00, 8'h00, 2'd0);
        drain_responses();

        sent = 0;
        while (sent < 600) begin
            burst_len = $urandom_range(20, 90);
            case ($urandom_range(0, 2))
                0:       share = 45;
                1:       share = 90;
                default: share = 15;
            endcase
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < burst_len; i++) random_request(share);
            sent += burst_len;
            if ($urandom_range(0, 5) == 0) drain_responses();
        end

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        saturate_note();

        drain_responses();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        int unsigned stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 17);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            sb.check_result(m_axis_tdata);
        end
    end

    // no request and no response for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
